/* hdl/bhr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhr_pkg: shared types, codes and tables for the barcode resolver
// Command and result beat types, whitelist slot layout, quality tables.
// ----------------------------------------------------------------------------
package bhr_pkg;

	localparam int MAX_BASES  = 16;
	localparam int WL_ENTRIES = 65536;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_COUNT   = 2'd1;
	localparam logic [1:0] OP_RESOLVE = 2'd2;
	localparam logic [1:0] OP_RSVD    = 2'd3;

	localparam logic [2:0] ST_LOADED    = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_COUNTED   = 3'd3;
	localparam logic [2:0] ST_NOT_WL    = 3'd4;
	localparam logic [2:0] ST_CANDIDATE = 3'd5;
	localparam logic [2:0] ST_UNSUP     = 3'd6;

	localparam logic signed [31:0] NONACGT_TERM = -32'sd90852;
	localparam logic [31:0] HASH_MULT    = 32'h9E37_79B1;
	localparam logic [63:0] MIS_SLOPE    = 64'd988952767;
	localparam logic [63:0] MIS_BASE_RND = 64'd4718536618;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] observed_bases;
		logic [15:0] non_acgt_mask;
		logic [4:0]  observed_length;
		logic [63:0] quality_first;
		logic [63:0] quality_second;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [31:0]        candidate_bases;
		logic               is_exact;
		logic signed [30:0] log_likelihood;
		logic [31:0]        exact_read_count;
		logic               last;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [31:0] count;
	} slot_t;

	// phred+33 byte to quality clamped to 0..60
	function automatic logic [5:0] phred(input logic [7:0] b);
		logic [7:0] p;
		p = (b < 8'd33) ? 8'd0 : b - 8'd33;
		return (p > 8'd60) ? 6'd60 : p[5:0];
	endfunction

	// ln(1 - 10^(-q/10)) in Q.16, floor of 1e-300 at q = 0
	function automatic logic signed [31:0] match_term(input logic [5:0] q);
		logic signed [31:0] v;
		case (q)
			6'd0:  v = -32'sd45270665;
			6'd1:  v = -32'sd103643;
			6'd2:  v = -32'sd65329;
			6'd3:  v = -32'sd45582;
			6'd4:  v = -32'sd33271;
			6'd5:  v = -32'sd24912;
			6'd6:  v = -32'sd18957;
			6'd7:  v = -32'sd14585;
			6'd8:  v = -32'sd11309;
			6'd9:  v = -32'sd8818;
			6'd10: v = -32'sd6905;
			6'd11: v = -32'sd5424;
			6'd12: v = -32'sd4271;
			6'd13: v = -32'sd3370;
			6'd14: v = -32'sd2662;
			6'd15: v = -32'sd2106;
			6'd16: v = -32'sd1667;
			6'd17: v = -32'sd1321;
			6'd18: v = -32'sd1047;
			6'd19: v = -32'sd830;
			6'd20: v = -32'sd659;
			6'd21: v = -32'sd523;
			6'd22: v = -32'sd415;
			6'd23: v = -32'sd329;
			6'd24: v = -32'sd261;
			6'd25: v = -32'sd208;
			6'd26: v = -32'sd165;
			6'd27: v = -32'sd131;
			6'd28: v = -32'sd104;
			6'd29: v = -32'sd83;
			6'd30: v = -32'sd66;
			6'd31: v = -32'sd52;
			6'd32: v = -32'sd41;
			6'd33: v = -32'sd33;
			6'd34: v = -32'sd26;
			6'd35: v = -32'sd21;
			6'd36: v = -32'sd16;
			6'd37: v = -32'sd13;
			6'd38: v = -32'sd10;
			6'd39: v = -32'sd8;
			6'd40: v = -32'sd7;
			6'd41: v = -32'sd5;
			6'd42: v = -32'sd4;
			6'd43: v = -32'sd3;
			6'd44: v = -32'sd3;
			6'd45: v = -32'sd2;
			6'd46: v = -32'sd2;
			6'd47: v = -32'sd1;
			6'd48: v = -32'sd1;
			6'd49: v = -32'sd1;
			6'd50: v = -32'sd1;
			6'd51: v = -32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	// magnitude of q*ln10/10 + ln3, rounded to Q.16
	function automatic logic [31:0] mis_term(input logic [5:0] q);
		logic [63:0] t;
		t = 64'(q) * MIS_SLOPE + MIS_BASE_RND;
		return t[47:16];
	endfunction

endpackage
`default_nettype wire

/* hdl/barcode_hamming1_resolver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barcode_hamming1_resolver: whitelist barcode resolver, one-substitution
// Loads, counts and resolves barcodes against a hashed whitelist table.
// ----------------------------------------------------------------------------
// Issue a command by raising start while busy is low. Results come out as
// single-cycle result_valid pulses and cannot be stalled; last marks the
// final beat of a command. After reset the slot memory is swept clear, one
// slot a cycle, with busy held high until the sweep ends. Every table
// lookup is a hash then linear probing through the single memory read
// port. Load and count do one lookup each. Resolve sums the likelihood
// over the L bases, does one exact lookup when no base is masked and, on
// a miss, the neighbor walk: 8*L iterator steps, one a cycle while no
// lookup runs, each substituted neighbor adding a lookup; a masked base
// walks 4 steps.
module barcode_hamming1_resolver #(
	parameter int WHITELIST_ENTRIES = bhr_pkg::WL_ENTRIES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [2:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  wire logic            start,
	output logic                 busy,
	input  wire bhr_pkg::cmd_t   cmd,
	output logic                 result_valid,
	output bhr_pkg::result_t     result
);

	localparam int AW = $clog2(WHITELIST_ENTRIES);
	localparam int CW = AW + 1;

	typedef enum logic [2:0] {S_IDLE, S_SUM, S_HASH, S_READ, S_CHECK, S_ENUM} state_t;

	state_t           state_q;
	logic [4:0]       blen_q;
	logic [1:0]       op_q;
	logic [31:0]      obs_q;
	logic [15:0]      m_q;
	logic [4:0]       len_q;
	logic [127:0]     qual_q;
	logic [3:0]       mpos_q;
	logic [31:0]      key_q;
	logic [3:0]       i_q;
	logic signed [31:0] sum_q;
	logic signed [31:0] delta_q;
	logic             in_enum_q;
	logic             ph_q;
	logic [3:0]       p_q;
	logic [1:0]       b_q;
	logic             edone_q;
	logic             pend_v_q;
	logic [31:0]      pend_cand_q;
	logic signed [31:0] pend_ll_q;
	logic [31:0]      pend_cnt_q;
	logic [AW-1:0]    addr_q;
	logic [CW-1:0]    probes_q;
	logic [CW-1:0]    loaded_q;
	logic             we_q;
	logic [AW-1:0]    waddr_q;
	bhr_pkg::slot_t   wdata_q;
	logic             res_v_q;
	bhr_pkg::result_t res_q;

	bhr_pkg::slot_t   rdata;
	logic             tbl_ready;

	bhr_table #(.ENTRIES(WHITELIST_ENTRIES)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (addr_q),
		.we     (we_q),
		.waddr  (waddr_q),
		.wdata  (wdata_q),
		.rdata  (rdata),
		.ready  (tbl_ready)
	);

	// config port
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {27'd0, blen_q};

	assign busy         = (state_q != S_IDLE) || !tbl_ready;
	assign result_valid = res_v_q;
	assign result       = res_q;

	// command preprocessing
	logic [4:0]  len_e;
	logic [15:0] bmask;
	logic [31:0] obs_m;
	logic [15:0] m_m;
	logic        len_ok;
	logic        multi;
	logic [3:0]  mpos;

	always_comb begin
		if (blen_q == 5'd0) begin
			len_e = 5'd1;
		end else if (blen_q > 5'(bhr_pkg::MAX_BASES)) begin
			len_e = 5'(bhr_pkg::MAX_BASES);
		end else begin
			len_e = blen_q;
		end
		mpos = 4'd0;
		for (int i = 0; i < 16; i++) begin
			bmask[i] = (5'(i) < len_e);
		end
		for (int i = 0; i < 16; i++) begin
			obs_m[2*i +: 2] = bmask[i] ? cmd.observed_bases[2*i +: 2] : 2'd0;
		end
		m_m = cmd.non_acgt_mask & bmask;
		for (int i = 0; i < 16; i++) begin
			if (m_m[i]) begin
				mpos = 4'(i);
			end
		end
		len_ok = (cmd.observed_length == len_e);
		multi  = ((m_m & (m_m - 16'd1)) != 16'd0);
	end

	// hash of the lookup key into a slot index
	logic [31:0]   prod;
	logic [AW-1:0] hraw;
	logic [AW-1:0] hidx;

	always_comb begin
		prod = key_q * bhr_pkg::HASH_MULT;
		hraw = prod[31 -: AW];
		if ({1'b0, hraw} >= CW'(WHITELIST_ENTRIES)) begin
			hidx = hraw - AW'(WHITELIST_ENTRIES);
		end else begin
			hidx = hraw;
		end
	end

	// likelihood sum term and neighbor walk
	logic [5:0]         q_i;
	logic [5:0]         q_p;
	logic signed [31:0] term;
	logic signed [31:0] delta;
	logic [1:0]         own;
	logic [31:0]        cand;
	logic               combo_ok;
	logic               plast;
	logic               masked;

	always_comb begin
		q_i  = bhr_pkg::phred(qual_q[{i_q, 3'b000} +: 8]);
		q_p  = bhr_pkg::phred(qual_q[{p_q, 3'b000} +: 8]);
		term = m_q[i_q] ? bhr_pkg::NONACGT_TERM : bhr_pkg::match_term(q_i);
		delta = -$signed(bhr_pkg::mis_term(q_p)) - bhr_pkg::match_term(q_p);
		own  = obs_q[{p_q, 1'b0} +: 2];
		cand = obs_q;
		cand[{p_q, 1'b0} +: 2] = b_q;
		masked = (m_q != 16'd0);
		if (masked) begin
			combo_ok = 1'b1;
		end else if (ph_q) begin
			combo_ok = (b_q > own);
		end else begin
			combo_ok = (b_q < own);
		end
		plast = (p_q == 4'(len_q - 5'd1));
	end

	// probe check
	logic        hit;
	logic        empty;
	logic        exhausted;
	logic [31:0] cnt_inc;

	always_comb begin
		hit       = rdata.valid && (rdata.key == key_q);
		empty     = !rdata.valid;
		exhausted = (probes_q == CW'(WHITELIST_ENTRIES - 1));
		cnt_inc   = (rdata.count == 32'hFFFF_FFFF) ? rdata.count : rdata.count + 32'd1;
	end

	function automatic bhr_pkg::result_t mk(input logic [2:0] st, input logic [31:0] cb,
			input logic ex, input logic signed [31:0] ll, input logic [31:0] cnt,
			input logic lst);
		bhr_pkg::result_t r;
		r.status           = st;
		r.candidate_bases  = cb;
		r.is_exact         = ex;
		r.log_likelihood   = ll[30:0];
		r.exact_read_count = cnt;
		r.last             = lst;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			blen_q      <= 5'd16;
			op_q        <= bhr_pkg::OP_LOAD;
			obs_q       <= '0;
			m_q         <= '0;
			len_q       <= '0;
			qual_q      <= '0;
			mpos_q      <= '0;
			key_q       <= '0;
			i_q         <= '0;
			sum_q       <= '0;
			delta_q     <= '0;
			in_enum_q   <= 1'b0;
			ph_q        <= 1'b0;
			p_q         <= '0;
			b_q         <= '0;
			edone_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_cand_q <= '0;
			pend_ll_q   <= '0;
			pend_cnt_q  <= '0;
			addr_q      <= '0;
			probes_q    <= '0;
			loaded_q    <= '0;
			we_q        <= 1'b0;
			waddr_q     <= '0;
			wdata_q     <= '0;
			res_v_q     <= 1'b0;
			res_q       <= '0;
		end else begin
			res_v_q <= 1'b0;
			we_q    <= 1'b0;
			if (psel && penable && pwrite && !paddr[2]) begin
				blen_q <= pwdata[4:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (start && tbl_ready) begin
						op_q   <= cmd.opcode;
						obs_q  <= obs_m;
						m_q    <= m_m;
						len_q  <= len_e;
						qual_q <= {cmd.quality_second, cmd.quality_first};
						mpos_q <= mpos;
						key_q  <= obs_m;
						unique case (cmd.opcode)
							bhr_pkg::OP_LOAD: begin
								if (!len_ok || m_m != 16'd0) begin
									res_v_q <= 1'b1;
									res_q   <= mk(bhr_pkg::ST_UNSUP, 32'd0, 1'b0, 32'sd0, 32'd0, 1'b1);
								end else begin
									state_q <= S_HASH;
								end
							end
							bhr_pkg::OP_COUNT: begin
								if (!len_ok || m_m != 16'd0) begin
									res_v_q <= 1'b1;
									res_q   <= mk(bhr_pkg::ST_NOT_WL, 32'd0, 1'b0, 32'sd0, 32'd0, 1'b1);
								end else begin
									state_q <= S_HASH;
								end
							end
							bhr_pkg::OP_RESOLVE: begin
								if (!len_ok || multi) begin
									res_v_q <= 1'b1;
									res_q   <= mk(bhr_pkg::ST_UNSUP, 32'd0, 1'b0, 32'sd0, 32'd0, 1'b1);
								end else begin
									i_q     <= 4'd0;
									sum_q   <= 32'sd0;
									state_q <= S_SUM;
								end
							end
							default: begin
								res_v_q <= 1'b1;
								res_q   <= mk(bhr_pkg::ST_UNSUP, 32'd0, 1'b0, 32'sd0, 32'd0, 1'b1);
							end
						endcase
					end
				end
				S_SUM: begin
					sum_q <= sum_q + term;
					i_q   <= i_q + 4'd1;
					if (i_q == 4'(len_q - 5'd1)) begin
						pend_v_q <= 1'b0;
						edone_q  <= 1'b0;
						ph_q     <= 1'b0;
						b_q      <= 2'd0;
						if (m_q == 16'd0) begin
							in_enum_q <= 1'b0;
							state_q   <= S_HASH;
						end else begin
							in_enum_q <= 1'b1;
							p_q       <= mpos_q;
							state_q   <= S_ENUM;
						end
					end
				end
				S_HASH: begin
					addr_q   <= hidx;
					probes_q <= '0;
					state_q  <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (hit) begin
						if (op_q == bhr_pkg::OP_LOAD) begin
							res_v_q <= 1'b1;
							res_q   <= mk(bhr_pkg::ST_DUP, obs_q, 1'b0, 32'sd0, 32'd0, 1'b1);
							state_q <= S_IDLE;
						end else if (op_q == bhr_pkg::OP_COUNT) begin
							we_q          <= 1'b1;
							waddr_q       <= addr_q;
							wdata_q       <= '{valid: rdata.valid, key: rdata.key, count: cnt_inc};
							res_v_q       <= 1'b1;
							res_q   <= mk(bhr_pkg::ST_COUNTED, obs_q, 1'b1, 32'sd0, cnt_inc, 1'b1);
							state_q <= S_IDLE;
						end else if (!in_enum_q) begin
							res_v_q <= 1'b1;
							res_q   <= mk(bhr_pkg::ST_CANDIDATE, obs_q, 1'b1, sum_q,
								rdata.count, 1'b1);
							state_q <= S_IDLE;
						end else begin
							// hold each hit back one so the final beat knows it is last
							if (pend_v_q) begin
								res_v_q <= 1'b1;
								res_q   <= mk(bhr_pkg::ST_CANDIDATE, pend_cand_q, 1'b0,
									pend_ll_q, pend_cnt_q, 1'b0);
							end
							pend_v_q    <= 1'b1;
							pend_cand_q <= key_q;
							pend_ll_q   <= masked ? sum_q : sum_q + delta_q;
							pend_cnt_q  <= rdata.count;
							state_q     <= S_ENUM;
						end
					end else if (empty || exhausted) begin
						if (op_q == bhr_pkg::OP_LOAD) begin
							res_v_q <= 1'b1;
							if (empty && loaded_q != CW'(WHITELIST_ENTRIES)) begin
								we_q     <= 1'b1;
								waddr_q  <= addr_q;
								wdata_q  <= '{valid: 1'b1, key: obs_q, count: 32'd0};
								loaded_q <= loaded_q + 1'b1;
								res_q    <= mk(bhr_pkg::ST_LOADED, obs_q, 1'b0, 32'sd0, 32'd0, 1'b1);
							end else begin
								res_q    <= mk(bhr_pkg::ST_FULL, obs_q, 1'b0, 32'sd0, 32'd0, 1'b1);
							end
							state_q <= S_IDLE;
						end else if (op_q == bhr_pkg::OP_COUNT) begin
							res_v_q <= 1'b1;
							res_q   <= mk(bhr_pkg::ST_NOT_WL, 32'd0, 1'b0, 32'sd0, 32'd0, 1'b1);
							state_q <= S_IDLE;
						end else begin
							if (!in_enum_q) begin
								in_enum_q <= 1'b1;
								p_q       <= 4'd0;
							end
							state_q <= S_ENUM;
						end
					end else begin
						addr_q   <= (addr_q == AW'(WHITELIST_ENTRIES - 1)) ? '0 : addr_q + 1'b1;
						probes_q <= probes_q + 1'b1;
						state_q  <= S_READ;
					end
				end
				S_ENUM: begin
					if (edone_q) begin
						res_v_q <= 1'b1;
						if (pend_v_q) begin
							res_q <= mk(bhr_pkg::ST_CANDIDATE, pend_cand_q, 1'b0,
								pend_ll_q, pend_cnt_q, 1'b1);
						end else begin
							res_q <= mk(bhr_pkg::ST_UNSUP, 32'd0, 1'b0, 32'sd0, 32'd0, 1'b1);
						end
						state_q <= S_IDLE;
					end else begin
						if (combo_ok) begin
							key_q   <= cand;
							delta_q <= delta;
							state_q <= S_HASH;
						end
						// lower substitutions by rising base, then higher ones by falling base
						if (b_q != 2'd3) begin
							b_q <= b_q + 2'd1;
						end else begin
							b_q <= 2'd0;
							if (masked) begin
								edone_q <= 1'b1;
							end else if (!ph_q) begin
								if (plast) begin
									ph_q <= 1'b1;
								end else begin
									p_q <= p_q + 4'd1;
								end
							end else if (p_q == 4'd0) begin
								edone_q <= 1'b1;
							end else begin
								p_q <= p_q - 4'd1;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/bhr_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhr_table: whitelist slot memory
// Open-addressed slot store with registered read and a clearing sweep
// after reset.
// ----------------------------------------------------------------------------
module bhr_table #(
	parameter int ENTRIES = bhr_pkg::WL_ENTRIES,
	localparam int AW = $clog2(ENTRIES)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [AW-1:0]  raddr,
	input  wire logic           we,
	input  wire logic [AW-1:0]  waddr,
	input  wire bhr_pkg::slot_t wdata,
	output bhr_pkg::slot_t      rdata,
	output logic                ready
);

	bhr_pkg::slot_t mem [ENTRIES];
	bhr_pkg::slot_t rdata_q;
	logic [AW:0]    clr_q;
	logic           clearing;

	assign clearing = (clr_q != (AW+1)'(ENTRIES));
	assign ready    = !clearing;
	assign rdata    = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule
`default_nettype wire

/* dv/barcode_hamming1_resolver_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barcode_hamming1_resolver_checker: result predictor and scoreboard
// Watches the command, result and register channels, predicts each result
// beat from its own whitelist model and compares field by field.
// ----------------------------------------------------------------------------
module barcode_hamming1_resolver_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	input  logic             pready,
	input  logic             start,
	input  logic             busy,
	input  bhr_pkg::cmd_t    cmd,
	input  logic             result_valid,
	input  bhr_pkg::result_t result,
	output int               errors,
	output int               pending
);

	localparam logic [2:0] ADDR_BARCODE_LENGTH = 3'd0;

	localparam int MATCH_Q16 [61] = '{
		-45270665, -103643, -65329, -45582, -33271, -24912, -18957, -14585,
		-11309, -8818, -6905, -5424, -4271, -3370, -2662, -2106,
		-1667, -1321, -1047, -830, -659, -523, -415, -329,
		-261, -208, -165, -131, -104, -83, -66, -52,
		-41, -33, -26, -21, -16, -13, -10, -8,
		-7, -5, -4, -3, -3, -2, -2, -1,
		-1, -1, -1, -1, 0, 0, 0, 0,
		0, 0, 0, 0, 0
	};

	logic [4:0]       len_reg;
	int               slot_of [bit [31:0]];
	logic [31:0]      read_counts [$];
	bhr_pkg::result_t beats_due [$];

	function automatic int bases_used();
		if (len_reg == 0) return 1;
		if (len_reg > bhr_pkg::MAX_BASES) return bhr_pkg::MAX_BASES;
		return len_reg;
	endfunction

	function automatic int qual(int i, logic [63:0] qf, logic [63:0] qs);
		int b;
		b = (i < 8) ? qf[8*i +: 8] : qs[8*(i-8) +: 8];
		b = (b < 33) ? 0 : b - 33;
		return (b > 60) ? 60 : b;
	endfunction

	function automatic longint read_loglik(logic [31:0] obs, logic [15:0] m, int len,
			logic [63:0] qf, logic [63:0] qs, logic [31:0] cand);
		longint sum;
		int q;
		logic [63:0] t;
		sum = 0;
		for (int i = 0; i < len; i++) begin
			if (m[i]) begin
				sum += -90852;
			end else begin
				q = qual(i, qf, qs);
				if (obs[2*i +: 2] == cand[2*i +: 2]) begin
					sum += MATCH_Q16[q];
				end else begin
					t = 64'(q) * 64'd988952767 + 64'd4718503850 + 64'd32768;
					sum -= longint'(t >> 16);
				end
			end
		end
		return sum;
	endfunction

	function automatic logic [31:0] lex_order(logic [31:0] b, int len);
		logic [31:0] k;
		k = 0;
		for (int i = 0; i < len; i++) k = (k << 2) | b[2*i +: 2];
		return k;
	endfunction

	function automatic bhr_pkg::result_t beat(logic [2:0] st, logic [31:0] cb, logic ex,
			longint ll, logic [31:0] cnt, logic lst);
		bhr_pkg::result_t r;
		r.status = st;
		r.candidate_bases = cb;
		r.is_exact = ex;
		r.log_likelihood = ll[30:0];
		r.exact_read_count = cnt;
		r.last = lst;
		return r;
	endfunction

	function automatic void add_beat(bhr_pkg::result_t r);
		beats_due = {beats_due, r};
	endfunction

	task automatic predict_beats(bhr_pkg::cmd_t c);
		int len, n;
		logic [31:0] obs, cnd, tmp;
		logic [15:0] m;
		logic len_ok, marked;
		logic [31:0] cands [$];
		len = bases_used();
		obs = c.observed_bases & 32'((64'd1 << (2*len)) - 64'd1);
		m = c.non_acgt_mask & 16'((17'd1 << len) - 17'd1);
		len_ok = (c.observed_length == len);
		case (c.opcode)
			bhr_pkg::OP_LOAD: begin
				if (!len_ok || m != 0) add_beat(beat(bhr_pkg::ST_UNSUP, 0, 0, 0, 0, 1));
				else if (slot_of.exists(obs)) add_beat(beat(bhr_pkg::ST_DUP, obs, 0, 0, 0, 1));
				else if (read_counts.size() >= bhr_pkg::WL_ENTRIES)
					add_beat(beat(bhr_pkg::ST_FULL, obs, 0, 0, 0, 1));
				else begin
					slot_of[obs] = read_counts.size();
					read_counts = {read_counts, 32'd0};
					add_beat(beat(bhr_pkg::ST_LOADED, obs, 0, 0, 0, 1));
				end
			end
			bhr_pkg::OP_COUNT: begin
				if (!len_ok || m != 0 || !slot_of.exists(obs)) begin
					add_beat(beat(bhr_pkg::ST_NOT_WL, 0, 0, 0, 0, 1));
				end else begin
					if (read_counts[slot_of[obs]] != 32'hFFFF_FFFF)
						read_counts[slot_of[obs]]++;
					add_beat(beat(bhr_pkg::ST_COUNTED, obs, 1, 0,
						read_counts[slot_of[obs]], 1));
				end
			end
			default: begin
				if (c.opcode == bhr_pkg::OP_RSVD || !len_ok) begin
					add_beat(beat(bhr_pkg::ST_UNSUP, 0, 0, 0, 0, 1));
				end else if (m == 0 && slot_of.exists(obs)) begin
					add_beat(beat(bhr_pkg::ST_CANDIDATE, obs, 1,
						read_loglik(obs, m, len, c.quality_first, c.quality_second, obs),
						read_counts[slot_of[obs]], 1));
				end else begin
					if ((m & (m - 1)) == 0) begin
						for (int p = 0; p < len; p++) begin
							marked = m[p];
							if (m != 0 && !marked) continue;
							for (int b = 0; b < 4; b++) begin
								if (!marked && b == obs[2*p +: 2]) continue;
								cnd = obs;
								cnd[2*p +: 2] = b[1:0];
								if (slot_of.exists(cnd) && cands.size() < 64) cands = {cands, cnd};
							end
						end
					end
					n = cands.size();
					if (n == 0) add_beat(beat(bhr_pkg::ST_UNSUP, 0, 0, 0, 0, 1));
					for (int k = 1; k < n; k++) begin
						for (int j = k; j > 0; j--) begin
							if (lex_order(cands[j-1], len) <= lex_order(cands[j], len)) break;
							tmp = cands[j]; cands[j] = cands[j-1]; cands[j-1] = tmp;
						end
					end
					for (int k = 0; k < n; k++)
						add_beat(beat(bhr_pkg::ST_CANDIDATE, cands[k], 0,
							read_loglik(obs, m, len, c.quality_first, c.quality_second,
								cands[k]),
							read_counts[slot_of[cands[k]]], k == n - 1));
				end
			end
		endcase
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		bhr_pkg::result_t w;
		if (!arst_n) begin
			len_reg = 5'd16;
		end else begin
			if (result_valid) begin
				if (beats_due.size() == 0) begin
					report("unexpected result beat", 64'(result.candidate_bases), 64'd0);
				end else begin
					w = beats_due.pop_front();
					if (result.status !== w.status)
						report("status", 64'(result.status), 64'(w.status));
					if (result.candidate_bases !== w.candidate_bases)
						report("candidate_bases", 64'(result.candidate_bases),
							64'(w.candidate_bases));
					if (result.is_exact !== w.is_exact)
						report("is_exact", 64'(result.is_exact), 64'(w.is_exact));
					if (result.log_likelihood !== w.log_likelihood)
						report("log_likelihood", 64'(result.log_likelihood),
							64'(w.log_likelihood));
					if (result.exact_read_count !== w.exact_read_count)
						report("exact_read_count", 64'(result.exact_read_count),
							64'(w.exact_read_count));
					if (result.last !== w.last) report("last", 64'(result.last), 64'(w.last));
				end
			end
			if (start && !busy) predict_beats(cmd);
			if (psel && penable && pwrite && pready && paddr == ADDR_BARCODE_LENGTH)
				len_reg = pwdata[4:0];
		end
		pending = beats_due.size();
	end

endmodule

/* dv/barcode_hamming1_resolver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barcode_hamming1_resolver_tb: stimulus and verdict for the resolver
// Directed loads, counts and resolves, then random traffic over several
// barcode lengths with random gaps; the checker scores every result beat.
// ----------------------------------------------------------------------------
module barcode_hamming1_resolver_tb;

	localparam logic [2:0] ADDR_BARCODE_LENGTH = 3'd0;
	localparam int IDLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 600;

	logic             clk;
	logic             arst_n;
	logic             psel, penable, pwrite;
	logic [2:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;
	logic             start;
	logic             busy;
	bhr_pkg::cmd_t    cmd;
	logic             result_valid;
	bhr_pkg::result_t result;
	int               errors, pending;
	int               idle_cycles;
	int               cur_len;
	bit               burst;
	logic [31:0]      pool [$];

	barcode_hamming1_resolver u_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.start, .busy, .cmd, .result_valid, .result
	);

	barcode_hamming1_resolver_checker u_checker (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.start, .busy, .cmd, .result_valid, .result, .errors, .pending
	);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic issue(bhr_pkg::cmd_t c);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = c;
		start = 1'b1;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(logic [31:0] v);
		drain();
		psel = 1'b1; pwrite = 1'b1; paddr = ADDR_BARCODE_LENGTH; pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
		@(negedge clk);
		cur_len = (v[4:0] == 0) ? 1 :
			(v[4:0] > bhr_pkg::MAX_BASES) ? bhr_pkg::MAX_BASES : int'(v[4:0]);
	endtask

	// well-formed command of the current length with random ignored bits
	function automatic bhr_pkg::cmd_t shaped(logic [1:0] op, logic [31:0] bases);
		bhr_pkg::cmd_t c;
		logic [31:0] bm;
		logic [15:0] lm;
		bm = 32'((64'd1 << (2*cur_len)) - 64'd1);
		lm = 16'((17'd1 << cur_len) - 17'd1);
		c.opcode = op;
		c.observed_bases = (bases & bm) | ($urandom & ~bm);
		c.non_acgt_mask = 16'($urandom) & ~lm;
		c.observed_length = 5'(cur_len);
		c.quality_first = rand64();
		c.quality_second = rand64();
		return c;
	endfunction

	function automatic logic [31:0] pick_known();
		return (pool.size() == 0) ? $urandom : pool[$urandom_range(0, pool.size() - 1)];
	endfunction

	function automatic bhr_pkg::cmd_t random_item();
		bhr_pkg::cmd_t c;
		int sel, p, p2;
		sel = $urandom_range(0, 99);
		p = $urandom_range(0, cur_len - 1);
		p2 = (p + 1 + $urandom_range(0, cur_len - 2)) % cur_len;
		if (sel < 22) begin
			c = shaped(bhr_pkg::OP_LOAD, (sel < 16) ? $urandom : pick_known());
		end else if (sel < 36) begin
			c = shaped(bhr_pkg::OP_COUNT, (sel < 32) ? pick_known() : $urandom);
		end else if (sel < 52) begin
			c = shaped(bhr_pkg::OP_RESOLVE, pick_known());
		end else if (sel < 70) begin
			c = shaped(bhr_pkg::OP_RESOLVE, pick_known());
			c.observed_bases[2*p +: 2] = c.observed_bases[2*p +: 2] +
				2'($urandom_range(1, 3));
		end else if (sel < 82) begin
			c = shaped(bhr_pkg::OP_RESOLVE, pick_known());
			c.non_acgt_mask[p] = 1'b1;
		end else if (sel < 86) begin
			c = shaped(bhr_pkg::OP_RESOLVE, $urandom);
			c.non_acgt_mask[p] = 1'b1;
			if (cur_len > 1) c.non_acgt_mask[p2] = 1'b1;
		end else if (sel < 90) begin
			c = shaped(2'($urandom_range(0, 2)), pick_known());
			c.non_acgt_mask[p] = 1'b1;
		end else if (sel < 95) begin
			c = shaped(2'($urandom_range(0, 2)), pick_known());
			c.observed_length = 5'($urandom);
		end else begin
			c = shaped(bhr_pkg::OP_RSVD, pick_known());
		end
		if (c.opcode == bhr_pkg::OP_LOAD) pool = {pool, c.observed_bases};
		return c;
	endfunction

	task automatic directed();
		bhr_pkg::cmd_t c;
		c = shaped(bhr_pkg::OP_LOAD, 32'h0000_0000); issue(c); pool = {pool, 32'h0};
		c = shaped(bhr_pkg::OP_LOAD, 32'hFFFF_FFFF); issue(c); pool = {pool, 32'hFFFF_FFFF};
		c = shaped(bhr_pkg::OP_LOAD, 32'h0000_0004); issue(c); pool = {pool, 32'h4};
		c = shaped(bhr_pkg::OP_LOAD, 32'h0000_000C); issue(c); pool = {pool, 32'hC};
		c = shaped(bhr_pkg::OP_LOAD, 32'h0000_0000); issue(c);
		c = shaped(bhr_pkg::OP_LOAD, 32'h1234_5678); c.non_acgt_mask = 16'h8000; issue(c);
		c = shaped(bhr_pkg::OP_LOAD, 32'h1234_5678); c.observed_length = 5'd15; issue(c);
		c = shaped(bhr_pkg::OP_COUNT, 32'h0000_0000); issue(c);
		c = shaped(bhr_pkg::OP_COUNT, 32'h0000_0000); issue(c);
		c = shaped(bhr_pkg::OP_COUNT, 32'h0000_0001); issue(c);
		c = shaped(bhr_pkg::OP_COUNT, 32'h0000_0000); c.non_acgt_mask = 16'h0001; issue(c);
		c = shaped(bhr_pkg::OP_COUNT, 32'hFFFF_FFFF); c.observed_length = 5'd31; issue(c);
		c = shaped(bhr_pkg::OP_RESOLVE, 32'h0000_0000);
		c.quality_first = '0; c.quality_second = '0; issue(c);
		c = shaped(bhr_pkg::OP_RESOLVE, 32'hFFFF_FFFF);
		c.quality_first = '1; c.quality_second = '1; issue(c);
		// one substitution away from three entries
		c = shaped(bhr_pkg::OP_RESOLVE, 32'h0000_0008); issue(c);
		c = shaped(bhr_pkg::OP_RESOLVE, 32'h7FFF_FFFF); issue(c);
		c = shaped(bhr_pkg::OP_RESOLVE, 32'h0000_0000); c.non_acgt_mask = 16'h0002; issue(c);
		c = shaped(bhr_pkg::OP_RESOLVE, 32'h0000_0000); c.non_acgt_mask = 16'h0003; issue(c);
		c = shaped(bhr_pkg::OP_RESOLVE, 32'hA5A5_A5A5); issue(c);
		c = shaped(bhr_pkg::OP_RESOLVE, 32'h0000_0000); c.observed_length = 5'd1; issue(c);
		c = shaped(bhr_pkg::OP_RSVD, 32'h0000_0000); issue(c);
	endtask

	initial begin
		int lengths [7] = '{4, 1, 0, 31, 9, 2, 16};
		bhr_pkg::cmd_t c;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		start = 1'b0;
		cmd = '0;
		cur_len = 16;
		burst = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		directed();
		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0) write_length(lengths[ph-1]);
			for (int i = 0; i < 56; i++) begin
				if ($urandom_range(0, 29) == 0) burst = !burst;
				if (i == 28) drain();
				c = random_item();
				issue(c);
			end
		end
		start = 1'b0;
		drain();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/bhr_pkg.sv
hdl/bhr_table.sv
hdl/barcode_hamming1_resolver.sv
dv/barcode_hamming1_resolver_checker.sv
dv/barcode_hamming1_resolver_tb.sv
